// ===== rtl/core/cbe_pkg.sv =====
package cbe_pkg;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIV_X,
        ST_CURVE,
        ST_CHECK,
        ST_SLOPE,
        ST_DIV_T,
        ST_UPDATE,
        ST_Y,
        ST_FINAL,
        ST_OUT
    } cbe_state_t;

    localparam logic [1:0] REG_X1 = 2'd0;
    localparam logic [1:0] REG_X2 = 2'd1;
    localparam logic [1:0] REG_Y1 = 2'd2;
    localparam logic [1:0] REG_Y2 = 2'd3;

    localparam logic [16:0] RST_X1 = 17'd0;
    localparam logic [16:0] RST_X2 = 17'd19661;
    localparam logic [16:0] RST_Y1 = 17'd45875;
    localparam logic [16:0] RST_Y2 = 17'd65536;

    // shift-add multiplier and divider handshake
    typedef struct packed {
        logic start;
        logic busy;
        logic done;
    } cbe_hs_t;

endpackage

// ===== rtl/core/cubic_bezier_easing_unit.sv =====
// channel | ports                         | beat
// input   | s_valid/s_ready, 4 fields     | one item: time, length, levels
// output  | m_valid/m_ready, eased_value  | one eased value per item
// config  | cfg_we/cfg_index/cfg_data     | one register write, no wait
// One item at a time. Work is done by the shared serial multiplier
// (8 products per curve point, 6 per slope) and the serial divider,
// for up to NEWTON_STEPS Newton steps per item at Q16.
// Reset (synchronous, aresetn low) loads the default control points.
// The result is held on m_eased_value until taken; s_ready stays low meanwhile.
module cubic_bezier_easing_unit
    import cbe_pkg::*;
#(
    parameter int NEWTON_STEPS = 8,
    parameter int FRAC_BITS    = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [15:0] s_elapsed_time,
    input  logic [15:0] s_anim_length,
    input  logic signed [15:0] s_start_level,
    input  logic signed [15:0] s_end_level,
    output logic        m_valid,
    input  logic        m_ready,
    output logic signed [15:0] m_eased_value,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [16:0] cfg_data
);
    localparam int W = 2 * FRAC_BITS + 16;
    localparam logic signed [W-1:0] ONE = W'(1) <<< FRAC_BITS;
    localparam logic signed [W-1:0] TOL = W'(((1 << FRAC_BITS) + 500) / 1000);
    localparam int SW = $clog2(NEWTON_STEPS + 1);

    // config registers
    logic [16:0] x1_reg, x2_reg, y1_reg, y2_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            x1_reg <= RST_X1; x2_reg <= RST_X2;
            y1_reg <= RST_Y1; y2_reg <= RST_Y2;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_X1:  x1_reg <= cfg_data;
                REG_X2:  x2_reg <= cfg_data;
                REG_Y1:  y1_reg <= cfg_data;
                REG_Y2:  y2_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    function automatic logic signed [W-1:0] to_q(input logic [16:0] v);
        logic [16:0] s;
        logic [W+16:0] p;
        s = (v > 17'd65536) ? 17'd65536 : v;
        p = (W+17)'(s) << FRAC_BITS;
        return $signed(W'(p >> 16));
    endfunction

    // shared serial units
    logic                  mul_go, div_go;
    logic signed [W-1:0]   mul_a, mul_b, div_n, div_d, quot;
    logic signed [2*W-1:0] prod;
    cbe_hs_t               mul_hs, div_hs;

    // product >> FRAC_BITS, truncated toward zero
    logic signed [2*W-1:0] prod_abs;
    logic signed [W-1:0]   qprod;
    assign prod_abs = prod[2*W-1] ? -prod : prod;
    assign qprod = prod[2*W-1] ? -W'(prod_abs >>> FRAC_BITS) : W'(prod_abs >>> FRAC_BITS);

    cbe_state_t state_reg, state_next;
    logic [3:0]  op_reg;        // micro-op within a polynomial sequence
    logic        run_reg;       // multiply or divide in flight
    logic [SW-1:0] it_reg;
    logic signed [W-1:0] x_reg, t_reg, p1_reg, p2_reg, dx_reg;
    logic signed [W-1:0] a_reg, b_reg, c_reg, acc_reg, tmp_reg;
    logic signed [15:0]  st_reg, en_reg, res_reg;
    logic [15:0] el_reg, len_reg;
    logic        slope_mode;

    // polynomial sequence: products in order, op index op_reg
    // curve : 0 a=mt*mt 1 b=mt*t 2 c=t*t 3 a*t 4 (.)*p1 5 b*t 6 (.)*p2 7 c*t
    // slope : 0..2 as above, 3 a*x1 4 b*(x2-x1) 5 c*(one-x2)
    logic signed [W-1:0] mt;
    assign mt = ONE - t_reg;
    logic [3:0] last_op;
    assign last_op = slope_mode ? 4'd5 : 4'd7;

    always_comb begin
        mul_a = mt; mul_b = mt;
        case (op_reg)
            4'd0: begin mul_a = mt;      mul_b = mt;      end
            4'd1: begin mul_a = mt;      mul_b = t_reg;   end
            4'd2: begin mul_a = t_reg;   mul_b = t_reg;   end
            4'd3: begin mul_a = a_reg;   mul_b = slope_mode ? p1_reg : t_reg; end
            4'd4: begin mul_a = slope_mode ? b_reg : tmp_reg;
                        mul_b = slope_mode ? p2_reg - p1_reg : p1_reg; end
            4'd5: begin mul_a = slope_mode ? c_reg : b_reg;
                        mul_b = slope_mode ? ONE - p2_reg : t_reg; end
            4'd6: begin mul_a = tmp_reg; mul_b = p2_reg;  end
            4'd7: begin mul_a = c_reg;   mul_b = t_reg;   end
            default: ;
        endcase
    end

    logic poly_state, poly_done;
    assign poly_state = (state_reg == ST_CURVE) || (state_reg == ST_SLOPE) ||
                        (state_reg == ST_Y);
    assign slope_mode = (state_reg == ST_SLOPE);
    assign poly_done  = poly_state && mul_hs.done && (op_reg == last_op);
    assign mul_go     = poly_state && !run_reg && !mul_hs.busy && !mul_hs.done;

    logic signed [W-1:0] adx, aslope, tnew;
    assign adx    = dx_reg[W-1] ? -dx_reg : dx_reg;
    assign aslope = acc_reg[W-1] ? -acc_reg : acc_reg;
    assign tnew   = t_reg + quot;

    logic accept;
    assign accept = s_valid && s_ready;
    assign div_go = (state_reg == ST_DIV_X || state_reg == ST_DIV_T) && !run_reg;
    // progress divide works from the captured beat, not the live inputs
    always_comb begin
        div_n = (W'(el_reg) <<< FRAC_BITS);
        div_d = W'(len_reg);
        if (state_reg == ST_DIV_T) begin
            div_n = dx_reg <<< FRAC_BITS;
            div_d = acc_reg;
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:   if (accept) state_next = ST_DIV_X;
            ST_DIV_X:  if (div_hs.done) state_next = ST_CURVE;
            ST_CURVE:  if (poly_done) state_next = ST_CHECK;
            ST_CHECK:  state_next = (adx < TOL) ? ST_Y : ST_SLOPE;
            ST_SLOPE:  if (poly_done) state_next = ST_DIV_T;
            ST_DIV_T:  if (aslope < TOL) state_next = ST_Y;
                       else if (div_hs.done) state_next = ST_UPDATE;
            ST_UPDATE: state_next = (it_reg == SW'(NEWTON_STEPS - 1)) ? ST_Y : ST_CURVE;
            ST_Y:      if (poly_done) state_next = ST_FINAL;
            ST_FINAL:  if (mul_hs.done) state_next = ST_OUT;
            ST_OUT:    if (m_ready) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        s_ready = (state_reg == ST_IDLE);
        m_valid = (state_reg == ST_OUT);
    end
    assign m_eased_value = res_reg;

    logic signed [W-1:0] fin, sum3;
    always_comb begin
        fin = W'(st_reg) + qprod;
        sum3 = acc_reg + qprod + qprod + qprod;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            run_reg   <= 1'b0;
            op_reg    <= '0;
            it_reg    <= '0;
        end else begin
            state_reg <= state_next;
            if (accept) begin
                el_reg <= s_elapsed_time; len_reg <= s_anim_length;
                st_reg <= s_start_level;  en_reg  <= s_end_level;
                p1_reg <= to_q(x1_reg);   p2_reg  <= to_q(x2_reg);
                it_reg <= '0;
                run_reg <= 1'b0;
            end
            if (div_go) run_reg <= 1'b1;
            if (mul_go) run_reg <= 1'b1;
            case (state_reg)
                ST_DIV_X: if (div_hs.done) begin
                    x_reg <= (len_reg == 16'd0 || el_reg >= len_reg) ? ONE : quot;
                    t_reg <= (len_reg == 16'd0 || el_reg >= len_reg) ? ONE : quot;
                    run_reg <= 1'b0; op_reg <= '0; acc_reg <= '0;
                end
                ST_CURVE, ST_SLOPE, ST_Y: if (mul_hs.done) begin
                    run_reg <= 1'b0;
                    op_reg  <= (op_reg == last_op) ? 4'd0 : op_reg + 4'd1;
                    case (op_reg)
                        4'd0: a_reg <= qprod;
                        4'd1: b_reg <= qprod;
                        4'd2: c_reg <= qprod;
                        4'd3: if (slope_mode) acc_reg <= qprod + qprod + qprod;
                              else tmp_reg <= qprod;
                        4'd4: if (slope_mode) acc_reg <= acc_reg + 6 * qprod;
                              else acc_reg <= qprod + qprod + qprod;
                        4'd5: if (slope_mode) acc_reg <= sum3;
                              else tmp_reg <= qprod;
                        4'd6: acc_reg <= sum3;
                        4'd7: acc_reg <= acc_reg + qprod;
                        default: ;
                    endcase
                    if (poly_done && state_reg == ST_CURVE) dx_reg <= x_reg - (acc_reg + qprod);
                end
                ST_CHECK: begin
                    op_reg <= '0;
                    if (adx < TOL) begin
                        p1_reg <= to_q(y1_reg); p2_reg <= to_q(y2_reg);
                    end
                end
                ST_DIV_T: begin
                    if (aslope < TOL) begin
                        p1_reg <= to_q(y1_reg); p2_reg <= to_q(y2_reg);
                        run_reg <= 1'b0;
                    end else if (div_hs.done) run_reg <= 1'b0;
                end
                ST_UPDATE: begin
                    t_reg  <= tnew[W-1] ? '0 : (tnew > ONE ? ONE : tnew);
                    it_reg <= it_reg + 1'b1;
                    op_reg <= '0;
                    if (it_reg == SW'(NEWTON_STEPS - 1)) begin
                        p1_reg <= to_q(y1_reg); p2_reg <= to_q(y2_reg);
                    end
                end
                ST_FINAL: if (mul_hs.done) begin
                    if (fin > W'(32767)) res_reg <= 16'sd32767;
                    else if (fin < -W'(32768)) res_reg <= -16'sd32768;
                    else res_reg <= 16'(fin);
                end
                default: ;
            endcase
            // final product (diff*y) reuses the multiplier, started on entry
            if (state_reg == ST_Y && poly_done) begin
                tmp_reg <= acc_reg + qprod;
            end
        end
    end

    // final multiply: diff * y, scaled by FRAC_BITS through qprod
    logic fin_go_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) fin_go_reg <= 1'b0;
        else fin_go_reg <= (state_reg == ST_Y) && poly_done;
    end
    logic signed [W-1:0] fa, fb;
    assign fa = W'(en_reg) - W'(st_reg);
    assign fb = tmp_reg;
    // multiplexed start for the final product
    logic signed [W-1:0] mul_a_f, mul_b_f;
    logic mul_go_f;
    assign mul_a_f = fin_go_reg ? fa : mul_a;
    assign mul_b_f = fin_go_reg ? fb : mul_b;
    assign mul_go_f = mul_go || fin_go_reg;

    cbe_mul #(.W(W)) u_mul (.aclk, .aresetn, .start(mul_go_f), .op_a(mul_a_f),
        .op_b(mul_b_f), .hs(mul_hs), .prod);
    cbe_div #(.W(W)) u_div (.aclk, .aresetn, .start(div_go), .num(div_n),
        .den(div_d), .hs(div_hs), .quot);
endmodule

// ===== rtl/core/cbe_mul.sv =====
// Bit-serial signed multiplier: one multiplier bit per cycle.
module cbe_mul
    import cbe_pkg::*;
#(
    parameter int W = 48
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                start,
    input  logic signed [W-1:0] op_a,
    input  logic signed [W-1:0] op_b,
    output cbe_hs_t             hs,
    output logic signed [2*W-1:0] prod
);
    localparam int CW = $clog2(W + 1);

    logic [CW-1:0]         cnt_reg;
    logic                  busy_reg, done_reg, neg_reg;
    logic [2*W-1:0]        acc_reg;
    logic [2*W-1:0]        mcand_reg;
    logic [W-1:0]          mplier_reg;
    logic [W-1:0]          abs_a, abs_b;

    assign abs_a = op_a[W-1] ? W'(-op_a) : W'(op_a);
    assign abs_b = op_b[W-1] ? W'(-op_b) : W'(op_b);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg   <= 1'b1;
                cnt_reg    <= CW'(W);
                acc_reg    <= '0;
                mcand_reg  <= {{W{1'b0}}, abs_a};
                mplier_reg <= abs_b;
                neg_reg    <= op_a[W-1] ^ op_b[W-1];
            end else if (busy_reg) begin
                if (mplier_reg[0]) acc_reg <= acc_reg + mcand_reg;
                mcand_reg  <= mcand_reg << 1;
                mplier_reg <= mplier_reg >> 1;
                cnt_reg    <= cnt_reg - 1'b1;
                if (cnt_reg == CW'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign hs.start = start;
    assign hs.busy  = busy_reg;
    assign hs.done  = done_reg;
    assign prod = neg_reg ? -$signed(acc_reg) : $signed(acc_reg);
endmodule

// ===== rtl/core/cbe_div.sv =====
// Restoring divider, one quotient bit per cycle, truncates toward zero.
module cbe_div
    import cbe_pkg::*;
#(
    parameter int W = 48
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                start,
    input  logic signed [W-1:0] num,
    input  logic signed [W-1:0] den,
    output cbe_hs_t             hs,
    output logic signed [W-1:0] quot
);
    localparam int CW = $clog2(W + 1);

    logic [CW-1:0] cnt_reg;
    logic          busy_reg, done_reg, neg_reg;
    logic [W-1:0]  q_reg, d_reg;
    logic [W:0]    r_reg;
    logic [W:0]    trial;

    assign trial = {r_reg[W-1:0], q_reg[W-1]} - {1'b0, d_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(W);
                r_reg    <= '0;
                q_reg    <= num[W-1] ? W'(-num) : W'(num);
                d_reg    <= den[W-1] ? W'(-den) : W'(den);
                neg_reg  <= num[W-1] ^ den[W-1];
            end else if (busy_reg) begin
                if (!trial[W]) begin
                    r_reg <= trial;
                    q_reg <= {q_reg[W-2:0], 1'b1};
                end else begin
                    r_reg <= {r_reg[W-1:0], q_reg[W-1]};
                    q_reg <= {q_reg[W-2:0], 1'b0};
                end
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CW'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign hs.start = start;
    assign hs.busy  = busy_reg;
    assign hs.done  = done_reg;
    assign quot = neg_reg ? -$signed(q_reg) : $signed(q_reg);
endmodule
